FILE: design/rk4ho_pkg.sv
// shared widths, constants and types for the rk4 oscillator stepper
`timescale 1ns / 1ps

package rk4ho_pkg;

  localparam int VALUE_W    = 40;
  localparam int FRAC_W     = 24;
  localparam int RATIO_W    = VALUE_W - 1;
  localparam int RATIO_HI_W = RATIO_W - FRAC_W;
  localparam int MUL_A_W    = FRAC_W + 1;
  localparam int MUL_P_W    = MUL_A_W + VALUE_W;
  localparam int PROD_W     = 2 * VALUE_W;
  localparam int RND_W      = PROD_W - FRAC_W;
  localparam int SUM_W      = RND_W + 1;
  // k1 + 2 k2 + 2 k3 + k4 needs three bits above a value
  localparam int ACC_W      = VALUE_W + 3;
  // magnitude plus three, padded to whole nibbles
  localparam int DIV_W      = ((VALUE_W + 2 + 3) / 4) * 4;
  localparam int DIV_STEPS  = DIV_W / 4;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int COUNT_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = VALUE_W;
  localparam int OP_W       = 4;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  localparam logic [FRAC_W-1:0]         STEP_SIZE_RST  = FRAC_W'(167772);
  localparam logic [RATIO_W-1:0]        RATIO_RST      = RATIO_W'(64'd2516582400);
  localparam logic signed [VALUE_W-1:0] INIT_POS_RST   = VALUE_W'(1677722);
  localparam logic signed [VALUE_W-1:0] INIT_VEL_RST   = '0;
  localparam logic [COUNT_W-1:0]        STEP_LIMIT_RST = COUNT_W'(1000);
  localparam logic [COUNT_W-1:0]        COUNT_MAX      = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SIZE  = 3'd0,
    CFG_RATIO      = 3'd1,
    CFG_INIT_POS   = 3'd2,
    CFG_INIT_VEL   = 3'd3,
    CFG_STEP_LIMIT = 3'd4
  } cfg_idx_t;

  // micro-op sequence of one rk4 step
  typedef enum logic [OP_W-1:0] {
    OP_SLOPE1 = 4'd0,
    OP_STX1   = 4'd1,
    OP_STV1   = 4'd2,
    OP_SLOPE2 = 4'd3,
    OP_STX2   = 4'd4,
    OP_STV2   = 4'd5,
    OP_SLOPE3 = 4'd6,
    OP_STX3   = 4'd7,
    OP_STV3   = 4'd8,
    OP_SLOPE4 = 4'd9,
    OP_FIN_X  = 4'd10,
    OP_FIN_V  = 4'd11
  } op_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

endpackage

FILE: design/rk4ho_if.sv
// valid/ready channels of the rk4 oscillator stepper
`timescale 1ns / 1ps

interface rk4ho_cmd_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface rk4ho_res_if import rk4ho_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] position;
  logic signed [VALUE_W-1:0] velocity;
  logic [COUNT_W-1:0]        step_index;
  logic                      run_done;
  modport source (output valid, output position, output velocity, output step_index,
                  output run_done, input ready);
  modport sink (input valid, input position, input velocity, input step_index,
                input run_done, output ready);
endinterface

FILE: design/rk4_harmonic_oscillator_step.sv
// top level of the rk4 spring-mass oscillator stepper
// Integrates x' = v, v' = -(k/m) x in signed Q16.24 with the classic fourth-order
// Runge-Kutta rule. A command beat with restart set loads position and velocity
// from the configuration registers and clears the step count. A beat with restart
// clear advances one step of size h in twelve passes through one shared 25x40
// multiply-accumulate (an h product or a split k/m product, then round, add and
// saturate), an accumulate step after each slope and a radix-16 divide by six
// that runs both weighted sums side by side. The block is busy while it steps and
// takes the next command the cycle after a result has moved into the output
// register, even while that result waits to be taken. Configuration must be
// written by the user through cfg_we, cfg_index and cfg_data only while the
// block is idle; the block does not enforce this. Writes to unknown indexes are
// dropped. No clearing pass follows reset.
`timescale 1ns / 1ps

module rk4_harmonic_oscillator_step import rk4ho_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  rk4ho_cmd_if.sink             cmd,
  rk4ho_res_if.source           res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_MUL_LO   = 9'b000000010,
    ST_MUL_HI   = 9'b000000100,
    ST_ROUND    = 9'b000001000,
    ST_ACC      = 9'b000010000,
    ST_DIV_PREP = 9'b000100000,
    ST_DIV      = 9'b001000000,
    ST_DIV_END  = 9'b010000000,
    ST_DONE     = 9'b100000000
  } state_t;

  // configuration
  logic [FRAC_W-1:0]         step_size;
  logic [RATIO_W-1:0]        ratio;
  logic signed [VALUE_W-1:0] init_pos;
  logic signed [VALUE_W-1:0] init_vel;
  logic [COUNT_W-1:0]        step_limit;

  // architectural state
  logic signed [VALUE_W-1:0] position_reg;
  logic signed [VALUE_W-1:0] velocity_reg;
  logic [COUNT_W-1:0]        step_counter;

  // working registers
  state_t                    state;
  op_t                       op;
  logic [DIV_CNT_W-1:0]      div_cnt;
  logic signed [VALUE_W-1:0] yx;
  logic signed [VALUE_W-1:0] yv;
  logic signed [VALUE_W-1:0] kv;
  logic signed [ACC_W-1:0]   acc_x;
  logic signed [ACC_W-1:0]   acc_v;
  logic signed [PROD_W-1:0]  prod;

  // output register
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_pos;
  logic signed [VALUE_W-1:0] out_vel;
  logic [COUNT_W-1:0]        out_index;
  logic                      out_done;

  // datapath
  logic                      cmd_take;
  logic                      out_load;
  logic                      is_slope;
  logic                      shift_half;
  logic                      base_v;
  logic                      acc_dbl;
  logic signed [VALUE_W-1:0] base;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [VALUE_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic [PROD_W-1:0]         half;
  logic signed [PROD_W-1:0]  prod_lo;
  logic signed [PROD_W-1:0]  prod_hi;
  logic signed [RND_W-1:0]   rnd;
  logic signed [SUM_W-1:0]   sum;
  logic [SUM_W-VALUE_W:0]    sum_top;
  logic signed [VALUE_W-1:0] res_val;
  logic signed [ACC_W-1:0]   acc_x_next;
  logic signed [ACC_W-1:0]   acc_v_next;
  logic signed [VALUE_W-1:0] avg_x;
  logic signed [VALUE_W-1:0] avg_v;
  div_ctl_t                  div_ctl;

  assign cmd.ready      = (state == ST_IDLE);
  assign cmd_take       = cmd.valid && cmd.ready;
  assign out_load       = (state == ST_DONE) && (!out_valid || res.ready);
  assign res.valid      = out_valid;
  assign res.position   = out_pos;
  assign res.velocity   = out_vel;
  assign res.step_index = out_index;
  assign res.run_done   = out_done;

  // op decode
  always_comb begin
    is_slope   = op inside {OP_SLOPE1, OP_SLOPE2, OP_SLOPE3, OP_SLOPE4};
    shift_half = op inside {OP_STX1, OP_STV1, OP_STX2, OP_STV2};
    base_v     = op inside {OP_STV1, OP_STV2, OP_STV3, OP_FIN_V};
    acc_dbl    = op inside {OP_SLOPE2, OP_SLOPE3};
    case (op)
      OP_SLOPE1, OP_SLOPE2, OP_SLOPE3, OP_SLOPE4, OP_FIN_X: begin
        mul_b = yx;
      end
      OP_STV1, OP_STV2, OP_STV3: begin
        mul_b = kv;
      end
      default: begin
        mul_b = yv;
      end
    endcase
    base = base_v ? velocity_reg : position_reg;
  end

  // shared multiply-accumulate, k/m split into low and high parts
  always_comb begin
    if (state == ST_MUL_HI) begin
      mul_a = MUL_A_W'(ratio[RATIO_W-1:FRAC_W]);
    end else if (is_slope) begin
      mul_a = {1'b0, ratio[FRAC_W-1:0]};
    end else begin
      mul_a = {1'b0, step_size};
    end
    mul_p   = mul_a * mul_b;
    half    = shift_half ? (PROD_W'(1) << FRAC_W) : (PROD_W'(1) << (FRAC_W - 1));
    prod_lo = PROD_W'(mul_p) + half;
    prod_hi = prod + (PROD_W'(mul_p) <<< FRAC_W);
    rnd     = shift_half ? RND_W'(prod >>> (FRAC_W + 1)) : RND_W'(prod >>> FRAC_W);
    // slope is the negated rounded product, a stage adds its base
    if (is_slope) begin
      sum = SUM_W'(~rnd) + SUM_W'(1);
    end else begin
      sum = SUM_W'(rnd) + SUM_W'(base);
    end
    sum_top = sum[SUM_W-1:VALUE_W-1];
    if ((&sum_top) || !(|sum_top)) begin
      res_val = sum[VALUE_W-1:0];
    end else begin
      res_val = sum[SUM_W-1] ? VAL_MIN : VAL_MAX;
    end
    acc_x_next = acc_x + (acc_dbl ? (ACC_W'(yv) <<< 1) : ACC_W'(yv));
    acc_v_next = acc_v + (acc_dbl ? (ACC_W'(kv) <<< 1) : ACC_W'(kv));
  end

  assign div_ctl.load = (state == ST_DIV_PREP);
  assign div_ctl.step = (state == ST_DIV);

  rk4ho_div6 u_div_x (
    .clk (clk),
    .ctl (div_ctl),
    .sum (acc_x),
    .avg (avg_x)
  );

  rk4ho_div6 u_div_v (
    .clk (clk),
    .ctl (div_ctl),
    .sum (acc_v),
    .avg (avg_v)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size  <= STEP_SIZE_RST;
      ratio      <= RATIO_RST;
      init_pos   <= INIT_POS_RST;
      init_vel   <= INIT_VEL_RST;
      step_limit <= STEP_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STEP_SIZE:  step_size  <= cfg_data[FRAC_W-1:0];
        CFG_RATIO:      ratio      <= cfg_data[RATIO_W-1:0];
        CFG_INIT_POS:   init_pos   <= cfg_data[VALUE_W-1:0];
        CFG_INIT_VEL:   init_vel   <= cfg_data[VALUE_W-1:0];
        CFG_STEP_LIMIT: step_limit <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      op           <= OP_SLOPE1;
      div_cnt      <= '0;
      position_reg <= INIT_POS_RST;
      velocity_reg <= INIT_VEL_RST;
      step_counter <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_take) begin
            if (cmd.restart) begin
              position_reg <= init_pos;
              velocity_reg <= init_vel;
              step_counter <= '0;
              state        <= ST_DONE;
            end else begin
              op    <= OP_SLOPE1;
              state <= ST_MUL_LO;
            end
          end
        end
        ST_MUL_LO: begin
          state <= is_slope ? ST_MUL_HI : ST_ROUND;
        end
        ST_MUL_HI: begin
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          if (op == OP_FIN_V) begin
            velocity_reg <= res_val;
            if (step_counter != COUNT_MAX) begin
              step_counter <= step_counter + COUNT_W'(1);
            end
            state <= ST_DONE;
          end else if (is_slope) begin
            state <= ST_ACC;
          end else begin
            if (op == OP_FIN_X) begin
              position_reg <= res_val;
            end
            op    <= op_t'(OP_W'(op) + OP_W'(1));
            state <= ST_MUL_LO;
          end
        end
        ST_ACC: begin
          op    <= op_t'(OP_W'(op) + OP_W'(1));
          state <= (op == OP_SLOPE4) ? ST_DIV_PREP : ST_MUL_LO;
        end
        ST_DIV_PREP: begin
          div_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= ST_DIV_END;
          end
        end
        ST_DIV_END: begin
          state <= ST_MUL_LO;
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // working datapath registers
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      yx    <= position_reg;
      yv    <= velocity_reg;
      acc_x <= '0;
      acc_v <= '0;
    end
    case (state)
      ST_MUL_LO: begin
        prod <= prod_lo;
      end
      ST_MUL_HI: begin
        prod <= prod_hi;
      end
      ST_ROUND: begin
        if (is_slope) begin
          kv <= res_val;
        end else if (op inside {OP_STX1, OP_STX2, OP_STX3}) begin
          yx <= res_val;
        end else if (op inside {OP_STV1, OP_STV2, OP_STV3}) begin
          yv <= res_val;
        end
      end
      ST_ACC: begin
        acc_x <= acc_x_next;
        acc_v <= acc_v_next;
      end
      ST_DIV_END: begin
        yx <= avg_x;
        yv <= avg_v;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos   <= position_reg;
      out_vel   <= velocity_reg;
      out_index <= step_counter;
      out_done  <= (step_counter == step_limit);
    end
  end

`ifndef SYNTH
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> !cmd.ready)
    else $error("command taken while a step is in flight");

  a_div_op: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (op == OP_FIN_X))
    else $error("divide running with wrong op pointer");

  a_restart_count: assert property (@(posedge clk) disable iff (rst)
    (cmd_take && cmd.restart) |=> (state == ST_DONE && step_counter == '0))
    else $error("restart did not clear the step count");

  a_result_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready && state == ST_DONE) |=> (state == ST_DONE))
    else $error("sequencer left done while the output slot was full");
`endif

endmodule

FILE: design/rk4ho_div6.sv
// radix-16 divide by six with round half away from zero and saturation
`timescale 1ns / 1ps

module rk4ho_div6 import rk4ho_pkg::*; (
  input  logic                      clk,
  input  div_ctl_t                  ctl,
  input  logic signed [ACC_W-1:0]   sum,
  output logic signed [VALUE_W-1:0] avg
);

  logic              neg;
  logic [DIV_W-1:0]  dm;
  logic [2:0]        rem;
  logic [DIV_W-1:0]  mag;
  logic [6:0]        dig;
  logic [11:0]       prodq;
  logic [3:0]        qd;
  logic [2:0]        rem_next;
  logic [VALUE_W-1:0] q;

  always_comb begin
    // magnitude plus three rounds the quotient to nearest
    if (sum[ACC_W-1]) begin
      mag = DIV_W'(~sum) + DIV_W'(4);
    end else begin
      mag = DIV_W'(sum) + DIV_W'(3);
    end
    dig      = {rem, dm[DIV_W-1 -: 4]};
    // digit below 96, times 43 over 256 gives floor of digit over six
    prodq    = 12'(dig) * 12'd43;
    qd       = prodq[11:8];
    rem_next = 3'(dig - 7'(qd) * 7'd6);
  end

  // quotient nibbles shift in from the bottom as dividend nibbles leave the top
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      neg <= sum[ACC_W-1];
      dm  <= mag;
      rem <= '0;
    end else if (ctl.step) begin
      dm  <= {dm[DIV_W-5:0], qd};
      rem <= rem_next;
    end
  end

  always_comb begin
    q = dm[VALUE_W-1:0];
    if (neg) begin
      avg = ~q + VALUE_W'(1);
    end else if (q[VALUE_W-1]) begin
      avg = VAL_MAX;
    end else begin
      avg = q;
    end
  end

endmodule
